FILE: src/ssd_pkg.sv
// Shared types, constants and the segment table of the seven-segment display driver.
`timescale 1ns / 1ps
package ssd_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned NUMBER_W = 32;
  localparam int unsigned RADIX_W  = 5;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned SEG_W    = 8;
  localparam int unsigned SEL_W    = 3;
  localparam int unsigned BITCNT_W = $clog2(NUMBER_W);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);
  localparam logic [SEG_W-1:0]   SEG_BLANK = 8'h00;

  // Request codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SHOW   = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_DIRECT = 2'd2
  } func_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_STORE
  } state_t;

  // Hexadecimal digit to segments a..g in bits 0..6, dp off
  function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'h0: s = 8'h3F;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5B;
      4'h3: s = 8'h4F;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6D;
      4'h6: s = 8'h7D;
      4'h7: s = 8'h07;
      4'h8: s = 8'h7F;
      4'h9: s = 8'h6F;
      4'hA: s = 8'h77;
      4'hB: s = 8'h7C;
      4'hC: s = 8'h39;
      4'hD: s = 8'h5E;
      4'hE: s = 8'h79;
      4'hF: s = 8'h71;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

FILE: src/ssd_if.sv
// Valid/ready channel interfaces for display requests and display outputs.
`timescale 1ns / 1ps
interface ssd_cmd_if;
  import ssd_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [NUMBER_W-1:0] number;
  logic [RADIX_W-1:0]  radix;
  logic [DIGIT_W-1:0]  digit_value;

  modport source (output valid, func, number, radix, digit_value, input ready);
  modport sink   (input valid, func, number, radix, digit_value, output ready);
endinterface

interface ssd_disp_if;
  import ssd_pkg::*;

  logic             valid;
  logic             ready;
  logic [SEG_W-1:0] segment_pattern;
  logic [SEL_W-1:0] digit_select;

  modport source (output valid, segment_pattern, digit_select, input ready);
  modport sink   (input valid, segment_pattern, digit_select, output ready);
endinterface

FILE: src/seven_segment_mux_display.sv
// Eight-digit multiplexed seven-segment driver: bit-serial radix conversion and scan.
// Show request: one restoring divide step per cycle, then one store step per digit;
//   zero finishes at acceptance.
// Tick and direct requests: result in the output register in the cycle after acceptance;
//   they are taken whenever the controller is idle and the output register is free.
// Synchronous reset blanks the digit buffer, zeroes the scan cursor, drops any result.
`timescale 1ns / 1ps
module seven_segment_mux_display #(
  parameter int unsigned NUM_DIGITS = 8
) (
  input logic     clk,
  input logic     rst,
  ssd_cmd_if.sink   cmd,
  ssd_disp_if.source disp
);
  import ssd_pkg::*;

  localparam int unsigned CW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [CW-1:0] LAST_POS = CW'(NUM_DIGITS - 1);

  state_t state, state_next;

  logic [SEG_W-1:0]    codes [NUM_DIGITS];
  logic [CW-1:0]       cursor;
  logic [CW-1:0]       pos;
  logic [NUMBER_W-1:0] num;
  logic [DIGIT_W-1:0]  rem;
  logic [RADIX_W-1:0]  radix;
  logic [BITCNT_W-1:0] bitcnt;

  logic                out_valid;
  logic [SEG_W-1:0]    out_seg;
  logic [SEL_W-1:0]    out_sel;

  logic                accept;
  logic                out_free;
  logic [RADIX_W-1:0]  radix_clamped;
  logic [RADIX_W-1:0]  trial;
  logic                qbit;
  logic [CW-1:0]       cursor_inc;
  logic                store_done;

  // Take a show request whenever idle; tick and direct need a free output slot
  assign out_free  = !out_valid || disp.ready;
  assign cmd.ready = (state == ST_IDLE) &&
                     ((cmd.func != FUNC_TICK && cmd.func != FUNC_DIRECT) || out_free);
  assign accept    = cmd.valid && cmd.ready;

  assign radix_clamped = (cmd.radix < RADIX_MIN) ? RADIX_MIN :
                         (cmd.radix > RADIX_MAX) ? RADIX_MAX : cmd.radix;

  // One restoring divide step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem, num[NUMBER_W-1]};
  assign qbit  = (trial >= radix);

  assign cursor_inc = (cursor == LAST_POS) ? '0 : cursor + CW'(1);
  assign store_done = (num == '0) || (pos == LAST_POS);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && cmd.func == FUNC_SHOW && cmd.number != '0) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (bitcnt == BITCNT_W'(NUMBER_W - 1)) state_next = ST_STORE;
      end
      ST_STORE: begin
        state_next = store_done ? ST_IDLE : ST_DIVIDE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Divider datapath and digit position
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept && cmd.func == FUNC_SHOW) begin
          num    <= cmd.number;
          radix  <= radix_clamped;
          rem    <= '0;
          bitcnt <= '0;
          pos    <= '0;
        end
      end
      ST_DIVIDE: begin
        rem    <= qbit ? DIGIT_W'(trial - radix) : trial[DIGIT_W-1:0];
        num    <= {num[NUMBER_W-2:0], qbit};
        bitcnt <= bitcnt + BITCNT_W'(1);
      end
      ST_STORE: begin
        rem    <= '0;
        bitcnt <= '0;
        pos    <= pos + CW'(1);
      end
      default: begin
        bitcnt <= '0;
      end
    endcase
  end

  // Digit buffer: write one code per stored digit (a single 0 for zero), blank positions above the last
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_DIGITS; k++) codes[k] <= SEG_BLANK;
    end else if (state == ST_IDLE && accept && cmd.func == FUNC_SHOW &&
                 cmd.number == '0) begin
      for (int k = 0; k < NUM_DIGITS; k++) codes[k] <= (k == 0) ? seg_code('0) : SEG_BLANK;
    end else if (state == ST_STORE) begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        if (CW'(k) == pos)                  codes[k] <= seg_code(rem);
        else if (store_done && CW'(k) > pos) codes[k] <= SEG_BLANK;
      end
    end
  end

  // Scan cursor advances on each tick
  always_ff @(posedge clk) begin
    if (rst) cursor <= '0;
    else if (accept && cmd.func == FUNC_TICK) cursor <= cursor_inc;
  end

  // Output register: load on tick or direct, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && cmd.func == FUNC_TICK) begin
      out_valid <= 1'b1;
    end else if (accept && cmd.func == FUNC_DIRECT) begin
      out_valid <= 1'b1;
    end else if (disp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.func == FUNC_TICK) begin
      out_seg <= codes[cursor_inc];
      out_sel <= SEL_W'(NUM_DIGITS - 1) - SEL_W'(cursor_inc);
    end else if (accept && cmd.func == FUNC_DIRECT) begin
      out_seg <= seg_code(cmd.digit_value);
      out_sel <= SEL_W'(NUM_DIGITS - 1) - SEL_W'(cursor);
    end
  end

  assign disp.valid           = out_valid;
  assign disp.segment_pattern = out_seg;
  assign disp.digit_select    = out_sel;

endmodule

FILE: tb/display_checker.sv
// Checker: predicts display outputs from accepted requests and compares them.
`timescale 1ns / 1ps
module display_checker #(
  parameter int unsigned NUM_DIGITS = 8
) (
  input  logic clk,
  input  logic rst,
  ssd_cmd_if   cmd,
  ssd_disp_if  disp,
  output int   mismatches,
  output int   outstanding
);
  import ssd_pkg::*;

  localparam int unsigned REPORT_MAX = 10;
  localparam int unsigned BUF_DEPTH  = 8;

  // Segment glyphs for hex digits 0..F, a..g in bits 0..6, dp off
  localparam logic [SEG_W-1:0] GLYPH [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  typedef struct packed {
    logic [SEG_W-1:0] pattern;
    logic [SEL_W-1:0] select;
  } shown_t;

  logic [SEG_W-1:0] glyph_buf [BUF_DEPTH];
  logic [SEL_W-1:0] cursor;
  shown_t           shown_q [$];
  int               errs = 0;

  // Convert a number to glyphs, least significant digit first, blank the rest
  function automatic void load_number(input logic [NUMBER_W-1:0] value,
                                      input logic [RADIX_W-1:0] base_in);
    int unsigned base;
    int unsigned pos;
    int unsigned k;
    base = (base_in < RADIX_MIN) ? 2 : (base_in > RADIX_MAX) ? 16 : base_in;
    pos = 0;
    while (value != 0 && pos < NUM_DIGITS) begin
      glyph_buf[pos] = GLYPH[value % base];
      value = value / base;
      pos++;
    end
    if (pos == 0) begin
      glyph_buf[0] = GLYPH[0];
      pos = 1;
    end
    for (k = pos; k < BUF_DEPTH; k++)
      glyph_buf[k] = SEG_BLANK;
  endfunction

  function automatic logic [SEL_W-1:0] current_select();
    return SEL_W'(NUM_DIGITS - 1 - cursor);
  endfunction

  always @(posedge clk) begin
    shown_t want;
    if (rst) begin
      for (int k = 0; k < BUF_DEPTH; k++)
        glyph_buf[k] = SEG_BLANK;
      cursor = '0;
      shown_q.delete();
    end else begin
      // advance the prediction on each accepted request
      if (cmd.valid && cmd.ready) begin
        case (cmd.func)
          FUNC_SHOW: begin
            load_number(cmd.number, cmd.radix);
          end
          FUNC_TICK: begin
            cursor = SEL_W'((cursor + 1) % NUM_DIGITS);
            shown_q.push_back('{glyph_buf[cursor], current_select()});
          end
          FUNC_DIRECT: begin
            shown_q.push_back('{GLYPH[cmd.digit_value], current_select()});
          end
          default: ;
        endcase
      end
      // compare each accepted output with the oldest prediction
      if (disp.valid && disp.ready) begin
        if (shown_q.size() == 0) begin
          errs++;
          if (errs <= REPORT_MAX)
            $display("unexpected output: segments %02h select %0d",
                     disp.segment_pattern, disp.digit_select);
        end else begin
          want = shown_q.pop_front();
          if (want.pattern !== disp.segment_pattern || want.select !== disp.digit_select) begin
            errs++;
            if (errs <= REPORT_MAX)
              $display("wrong output: segments exp %02h got %02h, select exp %0d got %0d",
                       want.pattern, disp.segment_pattern, want.select, disp.digit_select);
          end
        end
      end
    end
    mismatches  <= errs;
    outstanding <= shown_q.size();
  end

endmodule

FILE: tb/tb.sv
// Testbench top: clock, reset, request stimulus, output stalls and the verdict.
`timescale 1ns / 1ps
module tb;
  import ssd_pkg::*;

  localparam int unsigned NUM_DIGITS       = 8;
  localparam int unsigned RANDOM_PER_PHASE = 592;
  localparam int unsigned SETTLE_CYCLES    = 300;
  localparam int unsigned CYCLE_LIMIT      = 2_000_000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   src_idle = 0;
  int   dst_idle = 0;
  int   cycles = 0;
  int   mismatches;
  int   outstanding;

  ssd_cmd_if  cmd_ch ();
  ssd_disp_if disp_ch ();

  seven_segment_mux_display #(.NUM_DIGITS(NUM_DIGITS)) uut (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_ch),
    .disp (disp_ch)
  );

  display_checker #(.NUM_DIGITS(NUM_DIGITS)) disp_check (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_ch),
    .disp        (disp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the output side at random
  always @(posedge clk) begin
    disp_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= dst_idle);
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one request, idling first at random; valid stays high after acceptance
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [NUMBER_W-1:0] n,
                              input logic [RADIX_W-1:0] r, input logic [DIGIT_W-1:0] d);
    while ($urandom_range(99) < src_idle) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.func        <= f;
    cmd_ch.number      <= n;
    cmd_ch.radix       <= r;
    cmd_ch.digit_value <= d;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  task automatic send_tick();
    send_request(FUNC_TICK, $urandom, RADIX_W'($urandom), DIGIT_W'($urandom));
  endtask

  task automatic send_show(input logic [NUMBER_W-1:0] n, input logic [RADIX_W-1:0] r);
    send_request(FUNC_SHOW, n, r, DIGIT_W'($urandom));
  endtask

  task automatic send_direct(input logic [DIGIT_W-1:0] d);
    send_request(FUNC_DIRECT, $urandom, RADIX_W'($urandom), d);
  endtask

  // Hold requests until every predicted output has come
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // One random request: mostly shows and scan ticks, some direct digits, rare unused codes
  task automatic random_request();
    int unsigned pick;
    logic [NUMBER_W-1:0] n;
    logic [RADIX_W-1:0]  r;
    pick = $urandom_range(99);
    n = $urandom >> $urandom_range(31);
    case ($urandom_range(9))
      0: n = '0;
      1: n = '1;
      default: ;
    endcase
    r = ($urandom_range(9) == 0) ? RADIX_W'($urandom_range(31)) : RADIX_W'($urandom_range(2, 16));
    if (pick < 30)
      send_show(n, r);
    else if (pick < 75)
      send_tick();
    else if (pick < 97)
      send_direct(DIGIT_W'($urandom));
    else
      send_request(FUNC_UNUSED, n, r, DIGIT_W'($urandom));
  endtask

  initial begin
    cmd_ch.valid       <= 1'b0;
    cmd_ch.func        <= FUNC_SHOW;
    cmd_ch.number      <= '0;
    cmd_ch.radix       <= RADIX_MIN;
    cmd_ch.digit_value <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: blank buffer, digit extremes, zero, clamps, truncation, wrap, unused code
    send_tick();
    send_direct(4'h0);
    send_direct(4'hF);
    send_show(32'd0, 5'd10);
    send_tick();
    send_show(32'hFFFF_FFFF, 5'd31);
    repeat (NUM_DIGITS) send_tick();
    send_show(32'd123456789, 5'd10);
    send_tick();
    send_show(32'd5, 5'd0);
    send_tick();
    send_show(32'h0000_DEAD, 5'd1);
    send_direct(4'hA);
    send_request(FUNC_UNUSED, 32'hFFFF_FFFF, 5'd31, 4'hF);
    send_show(32'hFFFF_FFFF, 5'd2);
    send_tick();

    // Random: light sender idling, then heavy, then none
    for (int phase = 0; phase < 3; phase++) begin
      src_idle = (phase == 0) ? 6 : (phase == 1) ? 67 : 0;
      dst_idle = (phase == 0) ? 67 : (phase == 1) ? 6 : 0;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (phase == 1 && i == RANDOM_PER_PHASE / 2)
          drain();
        random_request();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
